// ===== rtl/stack_queue_pair_engine_top_defines.svh =====
`ifndef STACK_QUEUE_PAIR_ENGINE_TOP_DEFINES_SVH
`define STACK_QUEUE_PAIR_ENGINE_TOP_DEFINES_SVH

// check while out of reset
`define SQPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check at every edge, reset included
`define SQPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/sqpe_pkg.sv =====
`default_nettype none

package sqpe_pkg;

    localparam int DATA_W      = 32;
    localparam int SUM_W       = 33;
    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;
    localparam int MAX_RESULTS = 32;
    localparam int DRAIN_CNT_W = 5;
    localparam int PAIR_ITEMS  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SPUSH    = 4'd0,
        OP_SPOP     = 4'd1,
        OP_QPUSH    = 4'd2,
        OP_QPOP     = 4'd3,
        OP_SPEEK    = 4'd4,
        OP_QPEEK    = 4'd5,
        OP_S2Q      = 4'd6,
        OP_Q2S      = 4'd7,
        OP_SDRAIN   = 4'd8,
        OP_QDRAIN   = 4'd9,
        OP_QPARITY  = 4'd10,
        OP_SPARITY  = 4'd11,
        OP_SPAIRSUM = 4'd12,
        OP_QPAIRSUM = 4'd13,
        OP_QSEARCH  = 4'd14,
        OP_SSEARCH  = 4'd15
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_PUSH   = 2'd1,
        CH_POP    = 2'd2,
        CH_APPEND = 2'd3
    } t_chain_op;

    typedef struct packed {
        t_chain_op         op;
        logic [DATA_W-1:0] data;
    } t_chain_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] head0;
        logic [DATA_W-1:0] head1;
        logic              hit;
    } t_chain_view;

endpackage

`default_nettype wire

// ===== rtl/sqpe_cell.sv =====
`default_nettype none

module sqpe_cell (
    input  wire                         i_clk,
    input  wire  sqpe_pkg::t_chain_op   i_op,
    input  wire                         i_load,
    input  wire  [sqpe_pkg::DATA_W-1:0] i_prev,
    input  wire  [sqpe_pkg::DATA_W-1:0] i_next,
    input  wire  [sqpe_pkg::DATA_W-1:0] i_data,
    input  wire  [sqpe_pkg::DATA_W-1:0] i_key,
    output logic [sqpe_pkg::DATA_W-1:0] o_val,
    output logic                        o_hit
);
    import sqpe_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              r_hit;

    always_comb begin
        n_val = r_val;
        case (i_op)
            CH_PUSH:   n_val = i_prev;
            CH_POP:    n_val = i_next;
            CH_APPEND: begin
                if (i_load) begin
                    n_val = i_data;
                end
            end
            default:   n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_hit <= (r_val == i_key);
    end

    assign o_val = r_val;
    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ===== rtl/sqpe_chain.sv =====
`default_nettype none

module sqpe_chain #(
    parameter int DEPTH = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  sqpe_pkg::t_chain_ctl      i_ctl,
    input  wire  [sqpe_pkg::DATA_W-1:0]     i_key,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output sqpe_pkg::t_chain_view           o_view
);
    import sqpe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [DATA_W-1:0] w_val [DEPTH];
    logic [DEPTH-1:0]  w_hit;
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_load;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (i == 0) begin : g_first
            assign w_prev = i_ctl.data;
        end else begin : g_inner
            assign w_prev = w_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_next = w_val[i];
        end else begin : g_mid
            assign w_next = w_val[i+1];
        end

        assign w_valid[i] = CW'(i) < r_count;
        assign w_load[i]  = r_count == CW'(i);

        sqpe_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (i_ctl.op),
            .i_load (w_load[i]),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_data (i_ctl.data),
            .i_key  (i_key),
            .o_val  (w_val[i]),
            .o_hit  (w_hit[i])
        );
    end

    always_comb begin
        n_count = r_count;
        case (i_ctl.op)
            CH_PUSH:   n_count = r_count + CW'(1);
            CH_APPEND: n_count = r_count + CW'(1);
            CH_POP:    n_count = r_count - CW'(1);
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_view.head0 = w_val[0];
    assign o_view.head1 = w_val[1];
    assign o_view.hit   = |(w_hit & w_valid);

endmodule

`default_nettype wire

// ===== rtl/stack_queue_pair_engine_top.sv =====
// Channel | Dir | Beat contents (low bit first)
// s_axis  | in  | tdata: operation[3:0], value[35:4], zero pad to 40 bits
// m_axis  | out | tdata: status[2:0], first_value[34:3], second_value[66:35],
//         |     |        pair_sum[99:67], zero pad to 104 bits; tlast: last
// An item goes from idle to execute and back for push, pop, peek and move; pair and
// parity-remove ops add a second-pop state, search a search state and a drain of n
// items (n up to 32) a drain state; its first beat is registered from execute, search
// or drain. Cells shift one place per push or pop: one removal and one beat per cycle
// unless the output stalls. Reset is synchronous; it clears counts and control, and the
// cells need none. A stalled output holds its beat; input is taken between items.
`default_nettype none

module stack_queue_pair_engine_top #(
    parameter int STACK_DEPTH = 32,
    parameter int QUEUE_DEPTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // operation[3:0], value[35:4]
    input  wire  [sqpe_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // status[2:0], first_value[34:3], second_value[66:35], pair_sum[99:67]
    output logic [sqpe_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import sqpe_pkg::*;

    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int PAD_W = OUT_TDATA_W - STATUS_W - 2 * DATA_W - SUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP2,
        S_DRAIN,
        S_SRCH
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [DATA_W-1:0]      r_value;
    logic [DATA_W-1:0]      r_q_rear, n_q_rear;
    logic [DRAIN_CNT_W-1:0] r_drain_cnt, n_drain_cnt;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [DATA_W-1:0]      r_first, n_first;
    logic [DATA_W-1:0]      r_second, n_second;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_last, n_last;

    t_chain_ctl  s_ctl, q_ctl;
    t_chain_view s_view, q_view;
    logic [SCW-1:0] s_cnt;
    logic [QCW-1:0] q_cnt;

    logic              accept, out_free;
    logic              emit;
    t_status           e_status;
    logic [DATA_W-1:0] e_first, e_second;
    logic [SUM_W-1:0]  e_sum;
    logic              e_last;
    logic              s_empty, s_full, s_few, q_empty, q_full, q_few;
    logic              s_ok0, s_more, q_ok0, q_more, drain_cap;
    logic [SUM_W-1:0]  s_pair_sum, q_pair_sum;

    sqpe_chain #(.DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_key   (r_value),
        .o_count (s_cnt),
        .o_view  (s_view)
    );

    sqpe_chain #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_key   (r_value),
        .o_count (q_cnt),
        .o_view  (q_view)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign s_empty = (s_cnt == '0);
    assign s_full  = (s_cnt == SCW'(STACK_DEPTH));
    assign s_few   = (s_cnt < SCW'(PAIR_ITEMS));
    assign q_empty = (q_cnt == '0);
    assign q_full  = (q_cnt == QCW'(QUEUE_DEPTH));
    assign q_few   = (q_cnt < QCW'(PAIR_ITEMS));

    assign s_ok0     = !s_empty && !s_view.head0[0];
    assign s_more    = (s_cnt > SCW'(1)) && !s_view.head1[0];
    assign q_ok0     = !q_empty && q_view.head0[0];
    assign q_more    = (q_cnt > QCW'(1)) && q_view.head1[0];
    assign drain_cap = (r_drain_cnt == DRAIN_CNT_W'(MAX_RESULTS - 1));

    assign s_pair_sum = {s_view.head0[DATA_W-1], s_view.head0}
                      + {s_view.head1[DATA_W-1], s_view.head1};
    assign q_pair_sum = {q_view.head0[DATA_W-1], q_view.head0}
                      + {q_view.head1[DATA_W-1], q_view.head1};

    always_comb begin
        n_state     = r_state;
        n_q_rear    = r_q_rear;
        n_drain_cnt = r_drain_cnt;
        s_ctl.op    = CH_HOLD;
        s_ctl.data  = r_value;
        q_ctl.op    = CH_HOLD;
        q_ctl.data  = r_value;
        emit        = 1'b0;
        e_status    = ST_OK;
        e_first     = '0;
        e_second    = '0;
        e_sum       = '0;
        e_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    case (r_op)
                        OP_SPUSH: begin
                            emit    = 1'b1;
                            e_first = r_value;
                            if (s_full) begin
                                e_status = ST_FULL;
                            end else begin
                                s_ctl.op = CH_PUSH;
                            end
                        end
                        OP_QPUSH: begin
                            emit    = 1'b1;
                            e_first = r_value;
                            if (q_full) begin
                                e_status = ST_FULL;
                            end else begin
                                q_ctl.op = CH_APPEND;
                                n_q_rear = r_value;
                            end
                        end
                        OP_SPOP, OP_SPEEK: begin
                            emit = 1'b1;
                            if (s_empty) begin
                                e_status = ST_EMPTY;
                            end else begin
                                e_first = s_view.head0;
                                if (r_op == OP_SPOP) begin
                                    s_ctl.op = CH_POP;
                                end
                            end
                        end
                        OP_QPOP, OP_QPEEK: begin
                            emit = 1'b1;
                            if (q_empty) begin
                                e_status = ST_EMPTY;
                            end else begin
                                e_first = q_view.head0;
                                if (r_op == OP_QPOP) begin
                                    q_ctl.op = CH_POP;
                                end else begin
                                    e_second = r_q_rear;
                                end
                            end
                        end
                        OP_S2Q: begin
                            emit = 1'b1;
                            if (s_empty) begin
                                e_status = ST_EMPTY;
                            end else if (q_full) begin
                                e_status = ST_FULL;
                            end else begin
                                e_first    = s_view.head0;
                                s_ctl.op   = CH_POP;
                                q_ctl.op   = CH_APPEND;
                                q_ctl.data = s_view.head0;
                                n_q_rear   = s_view.head0;
                            end
                        end
                        OP_Q2S: begin
                            emit = 1'b1;
                            if (q_empty) begin
                                e_status = ST_EMPTY;
                            end else if (s_full) begin
                                e_status = ST_FULL;
                            end else begin
                                e_first    = q_view.head0;
                                q_ctl.op   = CH_POP;
                                s_ctl.op   = CH_PUSH;
                                s_ctl.data = q_view.head0;
                            end
                        end
                        OP_SDRAIN: begin
                            n_drain_cnt = '0;
                            if (s_empty) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_state = S_DRAIN;
                            end
                        end
                        OP_QDRAIN: begin
                            n_drain_cnt = '0;
                            if (q_empty) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_state = S_DRAIN;
                            end
                        end
                        OP_QPARITY, OP_QPAIRSUM: begin
                            emit = 1'b1;
                            if (q_few) begin
                                e_status = ST_EMPTY;
                            end else if (r_op == OP_QPARITY && r_value[0]) begin
                                e_first = r_value;
                                if (q_full) begin
                                    e_status = ST_FULL;
                                end else begin
                                    q_ctl.op = CH_APPEND;
                                    n_q_rear = r_value;
                                end
                            end else begin
                                e_first  = q_view.head0;
                                e_second = q_view.head1;
                                e_sum    = q_pair_sum;
                                q_ctl.op = CH_POP;
                                n_state  = S_POP2;
                            end
                        end
                        OP_SPARITY, OP_SPAIRSUM: begin
                            emit = 1'b1;
                            if (s_few) begin
                                e_status = ST_EMPTY;
                            end else if (r_op == OP_SPARITY && r_value[0]) begin
                                e_first = r_value;
                                if (s_full) begin
                                    e_status = ST_FULL;
                                end else begin
                                    s_ctl.op = CH_PUSH;
                                end
                            end else begin
                                e_first  = s_view.head0;
                                e_second = s_view.head1;
                                e_sum    = s_pair_sum;
                                s_ctl.op = CH_POP;
                                n_state  = S_POP2;
                            end
                        end
                        OP_QSEARCH: begin
                            if (q_empty) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            if (s_empty) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                    endcase
                end
            end
            S_POP2: begin
                n_state = S_IDLE;
                if (r_op == OP_SPARITY || r_op == OP_SPAIRSUM) begin
                    s_ctl.op = CH_POP;
                end else begin
                    q_ctl.op = CH_POP;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    emit        = 1'b1;
                    n_state     = S_IDLE;
                    n_drain_cnt = r_drain_cnt + DRAIN_CNT_W'(1);
                    if (r_op == OP_SDRAIN) begin
                        if (s_ok0) begin
                            e_first  = s_view.head0;
                            s_ctl.op = CH_POP;
                            e_last   = !(s_more && !drain_cap);
                            if (!e_last) begin
                                n_state = S_DRAIN;
                            end
                        end else begin
                            e_status = ST_NONE;
                        end
                    end else begin
                        if (q_ok0) begin
                            e_first  = q_view.head0;
                            q_ctl.op = CH_POP;
                            e_last   = !(q_more && !drain_cap);
                            if (!e_last) begin
                                n_state = S_DRAIN;
                            end
                        end else begin
                            e_status = ST_NONE;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_QSEARCH) begin
                        e_status = q_view.hit ? ST_FOUND : ST_NOT_FOUND;
                    end else begin
                        e_status = s_view.hit ? ST_FOUND : ST_NOT_FOUND;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_first     = r_first;
        n_second    = r_second;
        n_sum       = r_sum;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_status    = e_status;
            n_first     = e_first;
            n_second    = e_second;
            n_sum       = e_sum;
            n_last      = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_op    <= t_op'(i_s_axis_tdata[OP_W-1:0]);
            r_value <= i_s_axis_tdata[OP_W +: DATA_W];
        end
        r_q_rear    <= n_q_rear;
        r_drain_cnt <= n_drain_cnt;
        r_status    <= n_status;
        r_first     <= n_first;
        r_second    <= n_second;
        r_sum       <= n_sum;
        r_last      <= n_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_sum, r_second, r_first, r_status};

endmodule

`default_nettype wire

// ===== rtl/sqpe_checker.sv =====
`default_nettype none

`include "stack_queue_pair_engine_top_defines.svh"

module sqpe_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [sqpe_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire                              o_m_axis_tlast
);
    import sqpe_pkg::*;

    `SQPE_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output beat changed")
    `SQPE_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
    `SQPE_ASSERT(a_mid_drain, o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[STATUS_W-1:0] == ST_OK && o_m_axis_tdata[OUT_TDATA_W-1:STATUS_W+2*DATA_W] == '0, "non-final beat is not a plain removal")
    `SQPE_ASSERT(a_one_item, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "second item taken before the first was done")

endmodule

bind stack_queue_pair_engine_top sqpe_checker u_sqpe_checker (.*);

`default_nettype wire

// ===== dv/stack_queue_pair_engine_top_test.sv =====
`default_nettype none

module stack_queue_pair_engine_top_test;
    import sqpe_pkg::*;

    localparam int DEPTH       = 32;
    localparam int RANDOM_ITEMS = 330;
    localparam int TAIL_CYCLES = 48;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SCRIPT_LEN  = 28;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] first_value;
        logic [DATA_W-1:0] second_value;
        logic [SUM_W-1:0]  pair_sum;
        logic              last;
    } beat_t;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
        logic              typed;
        t_status           status;
        logic [DATA_W-1:0] first_value;
        logic [DATA_W-1:0] second_value;
        logic [SUM_W-1:0]  pair_sum;
    } script_row_t;

    typedef enum int {
        PH_MIX,
        PH_FILL_STACK,
        PH_FILL_QUEUE,
        PH_EVEN_STACK,
        PH_ODD_QUEUE,
        PH_SHUFFLE
    } phase_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_m_axis_tready = 1'b0;
    wire                    o_s_axis_tready;
    wire                    o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    wire                    o_m_axis_tlast;

    stack_queue_pair_engine_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [DATA_W-1:0] stk_mem [DEPTH];
    logic [DATA_W-1:0] q_mem [DEPTH];
    int                stk_cnt = 0;
    int                q_head = 0;
    int                q_tail = 0;
    int                q_cnt = 0;

    beat_t             step_beats [$];
    beat_t             pending_beats [$];
    logic [DATA_W-1:0] seen_values [$];
    int                mismatches = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    bit                steady = 1'b0;
    int                stall_left = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void add_beat(t_status st, logic [DATA_W-1:0] fv,
                                     logic [DATA_W-1:0] sv, logic [SUM_W-1:0] sm);
        beat_t b;
        b.status       = st;
        b.first_value  = fv;
        b.second_value = sv;
        b.pair_sum     = sm;
        b.last         = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic logic [SUM_W-1:0] sum33(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        return {a[DATA_W-1], a} + {b[DATA_W-1], b};
    endfunction

    function automatic void stack_put(logic [DATA_W-1:0] v);
        stk_mem[stk_cnt] = v;
        stk_cnt++;
    endfunction

    function automatic logic [DATA_W-1:0] stack_take();
        stk_cnt--;
        return stk_mem[stk_cnt];
    endfunction

    function automatic void queue_put(logic [DATA_W-1:0] v);
        q_mem[q_tail] = v;
        q_tail = (q_tail + 1) % DEPTH;
        q_cnt++;
    endfunction

    function automatic logic [DATA_W-1:0] queue_take();
        logic [DATA_W-1:0] v;
        v = q_mem[q_head];
        q_head = (q_head + 1) % DEPTH;
        q_cnt--;
        return v;
    endfunction

    function automatic void engine_step(t_op op, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        bit                hit;
        beat_t             tail;
        step_beats.delete();
        case (op)
            OP_SPUSH: begin
                if (stk_cnt >= DEPTH) add_beat(ST_FULL, v, '0, '0);
                else begin
                    stack_put(v);
                    add_beat(ST_OK, v, '0, '0);
                end
            end
            OP_QPUSH: begin
                if (q_cnt >= DEPTH) add_beat(ST_FULL, v, '0, '0);
                else begin
                    queue_put(v);
                    add_beat(ST_OK, v, '0, '0);
                end
            end
            OP_SPOP: begin
                if (stk_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else add_beat(ST_OK, stack_take(), '0, '0);
            end
            OP_QPOP: begin
                if (q_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else add_beat(ST_OK, queue_take(), '0, '0);
            end
            OP_SPEEK: begin
                if (stk_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else add_beat(ST_OK, stk_mem[stk_cnt-1], '0, '0);
            end
            OP_QPEEK: begin
                if (q_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else add_beat(ST_OK, q_mem[q_head], q_mem[(q_tail + DEPTH - 1) % DEPTH], '0);
            end
            OP_S2Q: begin
                if (stk_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else if (q_cnt >= DEPTH) add_beat(ST_FULL, '0, '0, '0);
                else begin
                    a = stack_take();
                    queue_put(a);
                    add_beat(ST_OK, a, '0, '0);
                end
            end
            OP_Q2S: begin
                if (q_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else if (stk_cnt >= DEPTH) add_beat(ST_FULL, '0, '0, '0);
                else begin
                    a = queue_take();
                    stack_put(a);
                    add_beat(ST_OK, a, '0, '0);
                end
            end
            OP_SDRAIN: begin
                if (stk_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else begin
                    while (stk_cnt > 0 && step_beats.size() < MAX_RESULTS
                           && !stk_mem[stk_cnt-1][0])
                        add_beat(ST_OK, stack_take(), '0, '0);
                    if (step_beats.size() == 0) add_beat(ST_NONE, '0, '0, '0);
                end
            end
            OP_QDRAIN: begin
                if (q_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else begin
                    while (q_cnt > 0 && step_beats.size() < MAX_RESULTS && q_mem[q_head][0])
                        add_beat(ST_OK, queue_take(), '0, '0);
                    if (step_beats.size() == 0) add_beat(ST_NONE, '0, '0, '0);
                end
            end
            OP_QPARITY, OP_QPAIRSUM: begin
                if (q_cnt < PAIR_ITEMS) add_beat(ST_EMPTY, '0, '0, '0);
                else if (op == OP_QPARITY && v[0]) begin
                    if (q_cnt >= DEPTH) add_beat(ST_FULL, v, '0, '0);
                    else begin
                        queue_put(v);
                        add_beat(ST_OK, v, '0, '0);
                    end
                end else begin
                    a = queue_take();
                    b = queue_take();
                    add_beat(ST_OK, a, b, sum33(a, b));
                end
            end
            OP_SPARITY, OP_SPAIRSUM: begin
                if (stk_cnt < PAIR_ITEMS) add_beat(ST_EMPTY, '0, '0, '0);
                else if (op == OP_SPARITY && v[0]) begin
                    if (stk_cnt >= DEPTH) add_beat(ST_FULL, v, '0, '0);
                    else begin
                        stack_put(v);
                        add_beat(ST_OK, v, '0, '0);
                    end
                end else begin
                    a = stack_take();
                    b = stack_take();
                    add_beat(ST_OK, a, b, sum33(a, b));
                end
            end
            OP_QSEARCH: begin
                if (q_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else begin
                    hit = 1'b0;
                    for (int n = 0; n < q_cnt; n++)
                        if (q_mem[(q_head + n) % DEPTH] == v) hit = 1'b1;
                    add_beat(hit ? ST_FOUND : ST_NOT_FOUND, '0, '0, '0);
                end
            end
            default: begin
                if (stk_cnt == 0) add_beat(ST_EMPTY, '0, '0, '0);
                else begin
                    hit = 1'b0;
                    for (int n = 0; n < stk_cnt; n++)
                        if (stk_mem[n] == v) hit = 1'b1;
                    add_beat(hit ? ST_FOUND : ST_NOT_FOUND, '0, '0, '0);
                end
            end
        endcase
        tail = step_beats.pop_back();
        tail.last = 1'b1;
        step_beats.push_back(tail);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20 && seen_values.size() != 0)
            return seen_values[$urandom_range(0, seen_values.size() - 1)];
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        if (r < 50) return $urandom_range(0, 15) - 8;
        return $urandom;
    endfunction

    task automatic send_item(t_op op, logic [DATA_W-1:0] val, bit typed, beat_t typed_beat);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - OP_W - DATA_W){1'b0}}, val, op};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        engine_step(op, val);
        if (typed) pending_beats.push_back(typed_beat);
        else foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
        if (op == OP_SPUSH || op == OP_QPUSH || op == OP_SPARITY || op == OP_QPARITY) begin
            seen_values.push_back(val);
            if (seen_values.size() > 16) void'(seen_values.pop_front());
        end
        items_sent++;
    endtask

    always @(posedge i_clk) begin : ready_gen
        int g;
        if (steady) begin
            i_m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            g = gap_len();
            i_m_axis_tready <= (g == 0);
            stall_left <= (g == 0) ? 0 : g - 1;
        end
    end

    always @(posedge i_clk) begin : beat_check
        beat_t got;
        beat_t want;
        got.status       = t_status'(o_m_axis_tdata[2:0]);
        got.first_value  = o_m_axis_tdata[34:3];
        got.second_value = o_m_axis_tdata[66:35];
        got.pair_sum     = o_m_axis_tdata[99:67];
        got.last         = o_m_axis_tlast;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: status %0d first %0d second %0d sum %0d last %0b",
                             got.status, $signed(got.first_value), $signed(got.second_value),
                             $signed(got.pair_sum), got.last);
            end else begin
                want = pending_beats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp st %0d f %0d s %0d sum %0d l %0b / act st %0d f %0d s %0d sum %0d l %0b",
                                 want.status, $signed(want.first_value),
                                 $signed(want.second_value), $signed(want.pair_sum), want.last,
                                 got.status, $signed(got.first_value),
                                 $signed(got.second_value), $signed(got.pair_sum), got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL stack_queue_pair_engine_top");
            $finish;
        end
    end

    initial begin : stimulus
        script_row_t script [SCRIPT_LEN];
        beat_t       row_beat;
        phase_t      phase;
        int          phase_len;
        int          r;
        t_op         op;
        logic [DATA_W-1:0] val;
        t_op         shuffle_ops [12];

        shuffle_ops = '{OP_S2Q, OP_Q2S, OP_SPEEK, OP_QPEEK, OP_SPAIRSUM, OP_QPAIRSUM,
                        OP_SPARITY, OP_QPARITY, OP_QSEARCH, OP_SSEARCH, OP_SPOP, OP_QPOP};

        script = '{
            '{OP_SPOP,     32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_QPOP,     32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_QPEEK,    32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_S2Q,      32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_SDRAIN,   32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_SSEARCH,  32'h5,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_SPAIRSUM, 32'h0,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_QPARITY,  32'h7,         1'b1, ST_EMPTY, 32'h0, 32'h0, 33'h0},
            '{OP_SPUSH,    32'h7fff_ffff, 1'b1, ST_OK, 32'h7fff_ffff, 32'h0, 33'h0},
            '{OP_SPUSH,    32'h7fff_ffff, 1'b1, ST_OK, 32'h7fff_ffff, 32'h0, 33'h0},
            '{OP_SPARITY,  32'h0,         1'b1, ST_OK, 32'h7fff_ffff, 32'h7fff_ffff,
              33'h0_ffff_fffe},
            '{OP_QPUSH,    32'h8000_0000, 1'b1, ST_OK, 32'h8000_0000, 32'h0, 33'h0},
            '{OP_QPUSH,    32'h8000_0000, 1'b1, ST_OK, 32'h8000_0000, 32'h0, 33'h0},
            '{OP_QPAIRSUM, 32'h0,         1'b1, ST_OK, 32'h8000_0000, 32'h8000_0000,
              33'h1_0000_0000},
            '{OP_SPUSH,    32'hffff_ffff, 1'b1, ST_OK, 32'hffff_ffff, 32'h0, 33'h0},
            '{OP_SPUSH,    32'h2,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_SDRAIN,   32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_SDRAIN,   32'h0,         1'b1, ST_NONE, 32'h0, 32'h0, 33'h0},
            '{OP_QPUSH,    32'h3,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_QPUSH,    32'h4,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_QPARITY,  32'h9,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_QPEEK,    32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_QDRAIN,   32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_QSEARCH,  32'h9,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_SSEARCH,  32'h1,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_S2Q,      32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_Q2S,      32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0},
            '{OP_SPEEK,    32'h0,         1'b0, ST_OK, 32'h0, 32'h0, 33'h0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row_beat.status       = script[i].status;
            row_beat.first_value  = script[i].first_value;
            row_beat.second_value = script[i].second_value;
            row_beat.pair_sum     = script[i].pair_sum;
            row_beat.last         = 1'b1;
            send_item(script[i].op, script[i].value, script[i].typed, row_beat);
        end

        row_beat = '0;
        while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
            phase     = phase_t'($urandom_range(0, 5));
            phase_len = $urandom_range(16, 48);
            steady    = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len; n++) begin
                r   = $urandom_range(0, 99);
                op  = t_op'($urandom_range(0, 15));
                val = rand_value();
                case (phase)
                    PH_FILL_STACK: if (r < 80) op = OP_SPUSH;
                    PH_FILL_QUEUE: if (r < 80) op = OP_QPUSH;
                    PH_EVEN_STACK: begin
                        if (n == phase_len - 1) op = OP_SDRAIN;
                        else if (r < 85) begin
                            op  = OP_SPUSH;
                            val = val & ~32'h1;
                        end
                    end
                    PH_ODD_QUEUE: begin
                        if (n == phase_len - 1) op = OP_QDRAIN;
                        else if (r < 85) begin
                            op  = OP_QPUSH;
                            val = val | 32'h1;
                        end
                    end
                    PH_SHUFFLE: op = shuffle_ops[$urandom_range(0, 11)];
                    default: ;
                endcase
                send_item(op, val, 1'b0, row_beat);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS stack_queue_pair_engine_top");
        end else begin
            $display("FAIL stack_queue_pair_engine_top");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== stack_queue_pair_engine_top.f =====
+incdir+rtl
rtl/sqpe_pkg.sv
rtl/sqpe_cell.sv
rtl/sqpe_chain.sv
rtl/stack_queue_pair_engine_top.sv
rtl/sqpe_checker.sv
dv/stack_queue_pair_engine_top_test.sv
